### rtl/rdz_pkg.sv
// Shared types, constants and register codes for the leftward distance-zone scan block.
`default_nettype none
package rdz_pkg;

  localparam int MAX_ZONES_DEF   = 16;
  localparam int ZONE_OFFSET_DEF = 2;

  localparam int DIST_W     = 24;
  localparam int STEP_W     = 13;
  localparam int ZCNT_W     = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  localparam logic [CFG_IDX_W-1:0] REG_NUM_ZONES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LATLON    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WRAP      = 2'd2;

  localparam logic       FUNC_CELL = 1'b1;
  localparam logic [7:0] SRC_CELL  = 8'd1;

  typedef struct packed {
    logic        func;
    logic [3:0]  entry_index;
    logic [23:0] threshold;
    logic        start_req;
    logic [3:0]  start_zone;
    logic        wrapped;
    logic [7:0]  source_value;
    logic [7:0]  zone_value;
  } in_word_t;

  typedef struct packed {
    logic [7:0] new_zone_value;
    logic       changed;
    logic       stop;
  } out_word_t;

  typedef struct packed {
    logic [4:0]  num_zones;
    logic        latlon_mode;
    logic [11:0] wrap_columns;
  } cfg_regs_t;

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_CELL  = 1'b1
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic [3:0]        entry;
    logic [23:0]       threshold;
    logic              start_req;
    logic [3:0]        start_zone;
    logic              wrapped;
    logic              is_source;
    logic [7:0]        zone_value;
    logic [ZCNT_W-1:0] search_end;
    logic [ZCNT_W-1:0] last_zone;
  } cmd_t;

endpackage
`default_nettype wire

### rtl/raster_distance_zone_left_scan_core.sv
// Top level of the leftward distance-zone scan block: configuration registers and wiring.
`default_nettype none
// Words enter through a two-deep command queue and are carried out one at a time by the
// engine. A threshold word produces no result. A cell word stops early on a wrap with
// no wrap width, or on the farthest-zone or source check; otherwise the zone search
// walks the limit table through its single registered read port, one entry per cycle
// from the lowest candidate zone, until a zone fits or the search end is reached. The
// result waits in an output register, so the engine can take the next queued word while
// an earlier result has not been popped, but holds its new result until that one is popped.
// Configuration registers: 0 zone count, 1 lat-long mode, 2 wrap width.
module raster_distance_zone_left_scan_core #(
  parameter int MAX_ZONES   = rdz_pkg::MAX_ZONES_DEF,
  parameter int ZONE_OFFSET = rdz_pkg::ZONE_OFFSET_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_push,
  input  rdz_pkg::in_word_t                    in_word,
  output logic                                 in_full,
  output logic                                 out_empty,
  input  logic                                 out_pop,
  output rdz_pkg::out_word_t                   out_word,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [rdz_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [rdz_pkg::CFG_DATA_W-1:0]       cfg_data
);
  import rdz_pkg::*;

  cfg_regs_t cfg_r, cfg_nxt;
  logic      q_valid;
  logic      q_pop;
  cmd_t      q_cmd;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_NUM_ZONES: cfg_nxt.num_zones    = cfg_data[4:0];
        REG_LATLON:    cfg_nxt.latlon_mode  = cfg_data[0];
        REG_WRAP:      cfg_nxt.wrap_columns = cfg_data[11:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{num_zones: 5'd1, latlon_mode: 1'b0, wrap_columns: 12'd0};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  rdz_front #(
    .MAX_ZONES  (MAX_ZONES),
    .ZONE_OFFSET(ZONE_OFFSET)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (in_push),
    .in_word(in_word),
    .full   (in_full),
    .cfg    (cfg_r),
    .q_valid(q_valid),
    .q_cmd  (q_cmd),
    .q_pop  (q_pop)
  );

  rdz_back #(
    .MAX_ZONES  (MAX_ZONES),
    .ZONE_OFFSET(ZONE_OFFSET)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd),
    .q_pop    (q_pop),
    .out_pop  (out_pop),
    .out_empty(out_empty),
    .out_word (out_word)
  );

endmodule
`default_nettype wire

### rtl/rdz_front.sv
// Front end: accepts input words, classifies them and queues commands for the engine.
`default_nettype none
module rdz_front #(
  parameter int MAX_ZONES   = rdz_pkg::MAX_ZONES_DEF,
  parameter int ZONE_OFFSET = rdz_pkg::ZONE_OFFSET_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  rdz_pkg::in_word_t in_word,
  output logic              full,
  input  rdz_pkg::cfg_regs_t cfg,
  output logic              q_valid,
  output rdz_pkg::cmd_t     q_cmd,
  input  logic              q_pop
);
  import rdz_pkg::*;

  localparam int QD  = 2;
  localparam int QAW = $clog2(QD);
  localparam int QCW = $clog2(QD + 1);

  logic [ZCNT_W-1:0] nz;
  logic [ZCNT_W-1:0] n_zones;
  logic [ZCNT_W-1:0] cur;
  logic [7:0]        zdiff;
  logic              keep;
  cmd_t              cmd;

  cmd_t              q_mem_r [QD];
  logic [QAW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [QCW-1:0]    cnt_r, cnt_nxt;
  logic              enq, deq;

  always_comb begin
    nz = ZCNT_W'(cfg.num_zones);
    if (nz == '0) begin
      n_zones = ZCNT_W'(1);
    end else if (nz > ZCNT_W'(MAX_ZONES)) begin
      n_zones = ZCNT_W'(MAX_ZONES);
    end else begin
      n_zones = nz;
    end

    zdiff = in_word.zone_value - 8'(ZONE_OFFSET);
    if (in_word.zone_value == '0) begin
      cur = n_zones;
    end else if (in_word.zone_value < 8'(ZONE_OFFSET)) begin
      cur = '0;
    end else if (zdiff > 8'(n_zones)) begin
      cur = n_zones;
    end else begin
      cur = ZCNT_W'(zdiff);
    end

    keep = (in_word.func == FUNC_CELL) ||
           (ZCNT_W'(in_word.entry_index) < ZCNT_W'(MAX_ZONES));

    cmd.kind       = (in_word.func == FUNC_CELL) ? CMD_CELL : CMD_WRITE;
    cmd.entry      = in_word.entry_index;
    cmd.threshold  = in_word.threshold;
    cmd.start_req  = in_word.start_req;
    cmd.start_zone = in_word.start_zone;
    cmd.wrapped    = in_word.wrapped;
    cmd.is_source  = (in_word.source_value == SRC_CELL);
    cmd.zone_value = in_word.zone_value;
    cmd.search_end = cur;
    cmd.last_zone  = n_zones - ZCNT_W'(1);
  end

  assign full    = (cnt_r == QCW'(QD));
  assign q_valid = (cnt_r != '0);
  assign q_cmd   = q_mem_r[rd_ptr_r];
  assign enq     = push && !full && keep;
  assign deq     = q_pop && q_valid;

  always_comb begin
    wr_ptr_nxt = enq ? wr_ptr_r + QAW'(1) : wr_ptr_r;
    rd_ptr_nxt = deq ? rd_ptr_r + QAW'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r + QCW'(enq) - QCW'(deq);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (enq) begin
      q_mem_r[wr_ptr_r] <= cmd;
    end
  end

endmodule
`default_nettype wire

### rtl/rdz_back.sv
// Engine: zone limit table, running distance and sequential zone search.
`default_nettype none
module rdz_back #(
  parameter int MAX_ZONES   = rdz_pkg::MAX_ZONES_DEF,
  parameter int ZONE_OFFSET = rdz_pkg::ZONE_OFFSET_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  rdz_pkg::cfg_regs_t cfg,
  input  logic               q_valid,
  input  rdz_pkg::cmd_t      q_cmd,
  output logic               q_pop,
  input  logic               out_pop,
  output logic               out_empty,
  output rdz_pkg::out_word_t out_word
);
  import rdz_pkg::*;

  localparam int AW = (MAX_ZONES > 1) ? $clog2(MAX_ZONES) : 1;
  localparam logic [DIST_W-1:0] DIST_MAX = '1;
  localparam logic [STEP_W-1:0] STEP_MAX = '1;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_DIST   = 5'b00010,
    S_CHECK  = 5'b00100,
    S_SEARCH = 5'b01000,
    S_EMIT   = 5'b10000
  } state_t;

  state_t            state_r, state_nxt;
  cmd_t              cmd_r, cmd_nxt;
  logic [DIST_W-1:0] dist_r, dist_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [ZCNT_W-1:0] lowest_r, lowest_nxt;
  logic [ZCNT_W-1:0] idx_r, idx_nxt;
  out_word_t         res_r, res_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_word_t         out_word_r, out_word_nxt;

  logic [DIST_W-1:0] zone_mem [MAX_ZONES];
  logic [DIST_W-1:0] rd_data_r;
  logic [ZCNT_W-1:0] rd_addr;
  logic              mem_we;

  logic [DIST_W-1:0] base_d;
  logic [STEP_W-1:0] base_s;
  logic [11:0]       wrap_add;
  logic [STEP_W-1:0] inc;
  logic [DIST_W+1:0] dist_sum;
  logic [DIST_W-1:0] dist_sat;
  logic [STEP_W:0]   step_sum;
  logic [STEP_W-1:0] step_sat;

  always_comb begin
    base_d   = cmd_r.start_req ? '0 : dist_r;
    base_s   = cmd_r.start_req ? STEP_W'(1) : step_r;
    wrap_add = cmd_r.wrapped ? cfg.wrap_columns - 12'd1 : '0;
    inc      = cfg.latlon_mode ? STEP_W'(1) : base_s;
    dist_sum = (DIST_W+2)'(base_d) + (DIST_W+2)'(wrap_add) + (DIST_W+2)'(inc);
    dist_sat = (dist_sum > (DIST_W+2)'(DIST_MAX)) ? DIST_MAX : dist_sum[DIST_W-1:0];
    step_sum = (STEP_W+1)'(base_s) + (STEP_W+1)'(2);
    step_sat = step_sum[STEP_W] ? STEP_MAX : step_sum[STEP_W-1:0];
  end

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    dist_nxt      = dist_r;
    step_nxt      = step_r;
    lowest_nxt    = lowest_r;
    idx_nxt       = idx_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_pop;
    out_word_nxt  = out_word_r;
    q_pop         = 1'b0;
    mem_we        = 1'b0;
    rd_addr       = idx_r + ZCNT_W'(1);
    case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop   = 1'b1;
          cmd_nxt = q_cmd;
          if (q_cmd.kind == CMD_WRITE) begin
            mem_we = 1'b1;
          end else begin
            state_nxt = S_DIST;
          end
        end
      end
      S_DIST: begin
        lowest_nxt = cmd_r.start_req ? ZCNT_W'(cmd_r.start_zone) : lowest_r;
        dist_nxt   = base_d;
        step_nxt   = base_s;
        if (cmd_r.wrapped && cfg.wrap_columns == '0) begin
          res_nxt   = '{new_zone_value: cmd_r.zone_value, changed: 1'b0, stop: 1'b1};
          state_nxt = S_EMIT;
        end else begin
          dist_nxt  = dist_sat;
          if (!cfg.latlon_mode) begin
            step_nxt = step_sat;
          end
          rd_addr   = cmd_r.last_zone;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        idx_nxt = lowest_r;
        rd_addr = lowest_r;
        if (dist_r > rd_data_r || cmd_r.is_source) begin
          res_nxt   = '{new_zone_value: cmd_r.zone_value, changed: 1'b0, stop: 1'b1};
          state_nxt = S_EMIT;
        end else begin
          state_nxt = S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (idx_r >= cmd_r.search_end) begin
          res_nxt   = '{new_zone_value: cmd_r.zone_value, changed: 1'b0, stop: 1'b0};
          state_nxt = S_EMIT;
        end else if (rd_data_r >= dist_r) begin
          res_nxt    = '{new_zone_value: 8'(idx_r) + 8'(ZONE_OFFSET), changed: 1'b1,
                         stop: 1'b0};
          lowest_nxt = idx_r;
          state_nxt  = S_EMIT;
        end else begin
          idx_nxt = idx_r + ZCNT_W'(1);
        end
      end
      S_EMIT: begin
        if (!out_valid_r || out_pop) begin
          out_valid_nxt = 1'b1;
          out_word_nxt  = res_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      dist_r      <= '0;
      step_r      <= STEP_W'(1);
      lowest_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      dist_r      <= dist_nxt;
      step_r      <= step_nxt;
      lowest_r    <= lowest_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    idx_r      <= idx_nxt;
    res_r      <= res_nxt;
    out_word_r <= out_word_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      zone_mem[AW'(q_cmd.entry)] <= q_cmd.threshold;
    end
    rd_data_r <= zone_mem[rd_addr[AW-1:0]];
  end

  assign out_empty = !out_valid_r;
  assign out_word  = out_word_r;

endmodule
`default_nettype wire

### rtl/rdz_checker.sv
// Port-level assertions for the scan block, bound to its top level.
`default_nettype none
module rdz_checker #(
  parameter int ZONE_OFFSET = rdz_pkg::ZONE_OFFSET_DEF
) (
  input logic               clk,
  input logic               rst_n,
  input logic               out_empty,
  input logic               out_pop,
  input rdz_pkg::out_word_t out_word
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result queue not empty after reset");

  a_hold_word: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_word)))
    else $error("waiting result word changed or vanished");

  a_stop_unchanged: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> !(out_word.stop && out_word.changed))
    else $error("stopped cell reported as rewritten");

  a_changed_code: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_word.changed) |-> (out_word.new_zone_value >= 8'(ZONE_OFFSET)))
    else $error("rewritten zone code below zone offset");

endmodule

bind raster_distance_zone_left_scan_core rdz_checker #(
  .ZONE_OFFSET(ZONE_OFFSET)
) u_rdz_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .out_empty(out_empty),
  .out_pop  (out_pop),
  .out_word (out_word)
);
`default_nettype wire
